@@ rtl/dad_pkg.sv @@
// dad_pkg: constants, item record and month-length helper for date_add_days
// depends on nothing; used by the interfaces, the month step stage and the top level
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

   // field widths of the channels
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 16;
   localparam int ADD_IN_W = 10;

   // most days added to one date; larger requests saturate here
   localparam int MAX_ADD_DAYS = 1023;
   localparam int REM_W        = $clog2(MAX_ADD_DAYS + 1);
   localparam int SUM_W        = REM_W + 1;

   // month steps: the first may use a single day, every other full step at least 28
   localparam int STEP_STAGES = (MAX_ADD_DAYS - 1) / 28 + 2;

   // years that one addition can reach, counted from the starting year
   localparam int YEAR_SPAN = (MAX_ADD_DAYS - 1) / 365 + 2;
   localparam int YOFF_W    = $clog2(YEAR_SPAN);

   // year / 25 by reciprocal: exact for every 16-bit year
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 20;
   localparam int RECIP25     = 671089;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam int CENTURY_DIV = 25;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // one date on its way through the month steps
   typedef struct packed {
      logic                 ok;
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
      logic [YEAR_W-1:0]    year;
      logic [REM_W-1:0]     remain;
      logic [YOFF_W-1:0]    yoff;
      logic [YEAR_SPAN-1:0] leap;
   } dad_item_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_FEB: begin
            len = leap ? 5'd29 : 5'd28;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dad_ifs.sv @@
// dad_ifs: request and response channel interfaces of date_add_days
// depends on dad_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface dad_req_if;
   logic                         valid;
   logic                         ready;
   logic [dad_pkg::DAY_W-1:0]    day_in;
   logic [dad_pkg::MONTH_W-1:0]  month_in;
   logic [dad_pkg::YEAR_W-1:0]   year_in;
   logic [dad_pkg::ADD_IN_W-1:0] days_to_add;

   modport source (output valid, day_in, month_in, year_in, days_to_add, input ready);
   modport sink (input valid, day_in, month_in, year_in, days_to_add, output ready);
endinterface

interface dad_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dad_pkg::DAY_W-1:0]   day_out;
   logic [dad_pkg::MONTH_W-1:0] month_out;
   logic [dad_pkg::YEAR_W-1:0]  year_out;
   logic                        date_valid;
   logic                        year_overflow;

   modport source (output valid, day_out, month_out, year_out, date_valid, year_overflow,
                   input ready);
   modport sink (input valid, day_out, month_out, year_out, date_valid, year_overflow,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/dad_month_step.sv @@
// dad_month_step: one registered month step of the date adder
// depends on dad_pkg for the item record and month lengths
`timescale 1ns / 1ps
`default_nettype none

module dad_month_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  up_valid,
   input  wire dad_pkg::dad_item_type up_item,
   output logic                       dn_valid,
   output dad_pkg::dad_item_type      dn_item
);
   import dad_pkg::*;

   logic             valid_ff;
   dad_item_type     item_ff;
   dad_item_type     item_in;
   logic [DAY_W-1:0] len;
   logic [SUM_W-1:0] sum;

   always_comb begin
      item_in = up_item;
      len     = month_len(up_item.month, up_item.leap[up_item.yoff]);
      sum     = SUM_W'(up_item.day) + SUM_W'(up_item.remain);
      if (up_item.remain != '0) begin
         if (sum > SUM_W'(len)) begin
            // finish this month, move to the first of the next
            item_in.remain = up_item.remain - (REM_W'(len) - REM_W'(up_item.day) + REM_W'(1));
            item_in.day    = DAY_W'(1);
            if (up_item.month == MONTH_DEC) begin
               item_in.month = MONTH_JAN;
               item_in.yoff  = up_item.yoff + YOFF_W'(1);
            end else begin
               item_in.month = up_item.month + MONTH_W'(1);
            end
         end else begin
            item_in.day    = sum[DAY_W-1:0];
            item_in.remain = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

endmodule

`default_nettype wire

@@ rtl/date_add_days_top.sv @@
// date_add_days_top: pipelined gregorian date plus day count
// depends on dad_pkg, dad_ifs (dad_req_if, dad_rsp_if) and dad_month_step
//
//   channel | role    | handshake     | payload
//   --------+---------+---------------+---------------------------------------------
//   req_ch  | sink    | valid / ready | day_in, month_in, year_in, days_to_add
//   rsp_ch  | source  | valid / ready | day_out, month_out, year_out, date_valid,
//           |         |               | year_overflow
//
// one item enters per cycle while no result is held back; the path runs through the front
// stages, the chain of month step stages and the result register
// front: input register, year / 25 product, year mod 25, leap lanes and date check
// reset clears every stage valid bit and the result register valid
// a result not taken holds the whole pipeline; req_ch.ready falls in the same
// cycle, so no item is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none

module date_add_days_top (
   input  wire logic  clock,
   input  wire logic  reset,
   dad_req_if.sink    req_ch,
   dad_rsp_if.source  rsp_ch
);
   import dad_pkg::*;

   // pipeline advance: everything moves when the result register is empty or being taken
   logic en;

   // stage 1: captured item, day count saturated
   logic                s1_valid_ff;
   logic [DAY_W-1:0]    s1_day_ff;
   logic [MONTH_W-1:0]  s1_month_ff;
   logic [YEAR_W-1:0]   s1_year_ff;
   logic [REM_W-1:0]    s1_rem_ff;
   logic [REM_W-1:0]    s1_rem_in;

   // stage 2: year / 25
   logic                s2_valid_ff;
   logic [DAY_W-1:0]    s2_day_ff;
   logic [MONTH_W-1:0]  s2_month_ff;
   logic [YEAR_W-1:0]   s2_year_ff;
   logic [REM_W-1:0]    s2_rem_ff;
   logic [QUOT_W-1:0]   s2_quot_ff;
   logic [PROD_W-1:0]   s2_prod;

   // stage 3: year mod 25
   logic                s3_valid_ff;
   logic [DAY_W-1:0]    s3_day_ff;
   logic [MONTH_W-1:0]  s3_month_ff;
   logic [YEAR_W-1:0]   s3_year_ff;
   logic [REM_W-1:0]    s3_rem_ff;
   logic [4:0]          s3_mod_ff;
   logic [YEAR_W-1:0]   s3_mod_wide;

   // stage 4 onwards: item records through the month steps
   logic                stage_valid [STEP_STAGES+1];
   dad_item_type        stage_item  [STEP_STAGES+1];
   logic                s4_valid_ff;
   dad_item_type        s4_item_ff;
   dad_item_type        s4_item_in;
   logic [YEAR_SPAN-1:0] leap;
   logic                date_ok;

   // result register
   logic                 rsp_valid_ff;
   logic [DAY_W-1:0]     rsp_day_ff;
   logic [MONTH_W-1:0]   rsp_month_ff;
   logic [YEAR_W-1:0]    rsp_year_ff;
   logic                 rsp_ok_ff;
   logic                 rsp_ovf_ff;
   logic [YEAR_W:0]      year_sum;
   dad_item_type         last_item;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      if (32'(req_ch.days_to_add) > 32'(MAX_ADD_DAYS)) begin
         s1_rem_in = REM_W'(MAX_ADD_DAYS);
      end else begin
         s1_rem_in = REM_W'(req_ch.days_to_add);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_day_ff   <= req_ch.day_in;
         s1_month_ff <= req_ch.month_in;
         s1_year_ff  <= req_ch.year_in;
         s1_rem_ff   <= s1_rem_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // quotient by reciprocal multiply, exact over the whole 16-bit range
   assign s2_prod = PROD_W'(s1_year_ff) * PROD_W'(RECIP25);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_day_ff   <= s1_day_ff;
         s2_month_ff <= s1_month_ff;
         s2_year_ff  <= s1_year_ff;
         s2_rem_ff   <= s1_rem_ff;
         s2_quot_ff  <= s2_prod[PROD_W-1:RECIP_SHIFT];
      end
   end

   // ---------------------------------------------------------------- stage 3
   assign s3_mod_wide = s2_year_ff - YEAR_W'(s2_quot_ff) * YEAR_W'(CENTURY_DIV);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_day_ff   <= s2_day_ff;
         s3_month_ff <= s2_month_ff;
         s3_year_ff  <= s2_year_ff;
         s3_rem_ff   <= s2_rem_ff;
         s3_mod_ff   <= s3_mod_wide[4:0];
      end
   end

   // ---------------------------------------------------------------- stage 4
   // leap flag for each year the addition can reach; with the year a multiple
   // of 4, a multiple of 100 is a multiple of 25 and of 400 also of 16
   for (genvar k = 0; k < YEAR_SPAN; k++) begin : g_leap
      localparam int KMOD = k % CENTURY_DIV;
      logic [YEAR_W:0] ysum;
      logic [5:0]      rsum;
      logic [5:0]      rmod;

      assign ysum = (YEAR_W+1)'(s3_year_ff) + (YEAR_W+1)'(k);
      assign rsum = 6'(s3_mod_ff) + 6'(KMOD);
      assign rmod = (rsum >= 6'(CENTURY_DIV)) ? rsum - 6'(CENTURY_DIV) : rsum;
      assign leap[k] = (ysum[1:0] == 2'b00) && ((rmod != 6'd0) || (ysum[3:0] == 4'd0));
   end

   // calendar check of the starting date
   assign date_ok = (s3_year_ff != '0) &&
                    (s3_month_ff >= MONTH_JAN) && (s3_month_ff <= MONTH_DEC) &&
                    (s3_day_ff != '0) &&
                    (s3_day_ff <= month_len(s3_month_ff, leap[0]));

   always_comb begin
      s4_item_in.ok     = date_ok;
      s4_item_in.day    = s3_day_ff;
      s4_item_in.month  = s3_month_ff;
      s4_item_in.year   = s3_year_ff;
      // an invalid date has nothing to add and passes through unchanged
      s4_item_in.remain = date_ok ? s3_rem_ff : '0;
      s4_item_in.yoff   = '0;
      s4_item_in.leap   = leap;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_item_ff <= s4_item_in;
      end
   end

   // front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------- month steps
   assign stage_valid[0] = s4_valid_ff;
   assign stage_item[0]  = s4_item_ff;

   for (genvar g = 0; g < STEP_STAGES; g++) begin : g_step
      dad_month_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (stage_valid[g]),
         .up_item  (stage_item[g]),
         .dn_valid (stage_valid[g+1]),
         .dn_item  (stage_item[g+1])
      );
   end

   // ---------------------------------------------------------------- result
   // year offset folded back into the full year; carry out is the overflow
   assign last_item = stage_item[STEP_STAGES];
   assign year_sum  = (YEAR_W+1)'(last_item.year) + (YEAR_W+1)'(last_item.yoff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= stage_valid[STEP_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_day_ff   <= last_item.day;
         rsp_month_ff <= last_item.month;
         rsp_year_ff  <= year_sum[YEAR_W-1:0];
         rsp_ok_ff    <= last_item.ok;
         rsp_ovf_ff   <= last_item.ok && year_sum[YEAR_W];
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.day_out       = rsp_day_ff;
   assign rsp_ch.month_out     = rsp_month_ff;
   assign rsp_ch.year_out      = rsp_year_ff;
   assign rsp_ch.date_valid    = rsp_ok_ff;
   assign rsp_ch.year_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   // every valid date has used up its days by the last month step
   a_days_used: assert property (@(posedge clock) disable iff (reset)
      stage_valid[STEP_STAGES] && last_item.ok |-> last_item.remain == '0)
      else $error("days left after the last month step");

   // overflow is only ever flagged for a valid date
   a_ovf_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.date_valid |-> !rsp_ch.year_overflow)
      else $error("year overflow on an invalid date");

   // a valid result is a real calendar position
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.date_valid |->
         rsp_ch.month_out >= MONTH_JAN && rsp_ch.month_out <= MONTH_DEC &&
         rsp_ch.day_out != '0)
      else $error("valid result outside the calendar");

   // an item accepted at the input shows up in stage 1 on the next edge
   a_front_fill: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");
`endif

endmodule

`default_nettype wire

@@ test/date_add_days_top_tb.sv @@
// date_add_days_top_tb: self-checking bench for the gregorian date plus day count block
// depends on dad_pkg, dad_ifs and date_add_days_top; predicts every result on its own
// directed corner dates first, then about 1200 random dates with idle and stall bursts
`timescale 1ns / 1ps

module date_add_days_top_tb;
   import dad_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_DATES  = 1200;
   localparam int QUIET_TAIL    = 200;   // last dates run with no idling at all
   localparam int DRAIN_CYCLES  = 60;    // pipeline is 43 deep
   localparam int WATCHDOG_LIMIT = 2000;

   // one request item as driven on req_ch
   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [ADD_IN_W-1:0] add_days;
   } date_request_type;

   // one result item as seen on rsp_ch
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               date_ok;
      logic               year_wrap;
   } date_result_type;

   // keeps the dates in flight and their predicted sums
   class date_sum_tracker_type;
      date_result_type pending_sums[$];
      int              dates_noted;
      int              valid_dates;
      int              wrapped_years;
      int              sums_checked;
      int              mismatches;

      function bit leap_year(int unsigned year);
         return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      endfunction

      function int unsigned month_days(int unsigned month, int unsigned year);
         if (month == MONTH_FEB)
            return leap_year(year) ? 29 : 28;
         if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
             month == MONTH_NOV)
            return 30;
         return 31;
      endfunction

      // walk the date forward a month at a time, year kept wide to see the wrap
      function date_result_type advance_date(date_request_type req);
         date_result_type sum;
         int unsigned     day;
         int unsigned     month;
         int unsigned     year;
         int unsigned     left;
         int unsigned     len;
         day   = req.day;
         month = req.month;
         year  = req.year;
         left  = req.add_days;
         if (left > MAX_ADD_DAYS)
            left = MAX_ADD_DAYS;
         sum.date_ok = (year > 0) && (month >= 1) && (month <= 12) &&
                       (day >= 1) && (day <= month_days(month, year));
         sum.year_wrap = 1'b0;
         if (sum.date_ok) begin
            while (left > 0) begin
               len = month_days(month, year);
               if (day + left > len) begin
                  left  -= len - day + 1;
                  day    = 1;
                  month += 1;
                  if (month > 12) begin
                     month = 1;
                     year += 1;
                  end
               end else begin
                  day += left;
                  left = 0;
               end
            end
            sum.year_wrap = (year > 65535);
         end
         sum.day   = DAY_W'(day);
         sum.month = MONTH_W'(month);
         sum.year  = YEAR_W'(year);
         return sum;
      endfunction

      function void note_request(date_request_type req);
         date_result_type sum;
         sum = advance_date(req);
         pending_sums.push_back(sum);
         dates_noted++;
         if (sum.date_ok)
            valid_dates++;
         if (sum.year_wrap)
            wrapped_years++;
      endfunction

      function void check_result(date_result_type got);
         date_result_type want;
         bit              bad;
         bad = 1'b0;
         if (pending_sums.size() == 0) begin
            $error("result item with no date pending: day %0d month %0d year %0d",
                   got.day, got.month, got.year);
            mismatches++;
            return;
         end
         want = pending_sums.pop_front();
         sums_checked++;
         if (got.day !== want.day) begin
            $error("day_out: expected %0d, actual %0d", want.day, got.day);
            bad = 1'b1;
         end
         if (got.month !== want.month) begin
            $error("month_out: expected %0d, actual %0d", want.month, got.month);
            bad = 1'b1;
         end
         if (got.year !== want.year) begin
            $error("year_out: expected %0d, actual %0d", want.year, got.year);
            bad = 1'b1;
         end
         if (got.date_ok !== want.date_ok) begin
            $error("date_valid: expected %0b, actual %0b", want.date_ok, got.date_ok);
            bad = 1'b1;
         end
         if (got.year_wrap !== want.year_wrap) begin
            $error("year_overflow: expected %0b, actual %0b", want.year_wrap, got.year_wrap);
            bad = 1'b1;
         end
         if (bad)
            mismatches++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   dad_req_if req_if ();
   dad_rsp_if rsp_if ();

   date_add_days_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   date_sum_tracker_type tracker = new();

   // idling switches, flipped by the stimulus as it goes through its segments
   bit req_idling = 1'b0;
   bit rsp_idling = 1'b0;
   int stall_left = 0;

   always #HALF_PERIOD clock = ~clock;

   // result side: ready changes on the falling edge and drops low in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left   = stall_left - 1;
      end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
         rsp_if.ready = 1'b0;
         stall_left   = $urandom_range(1, 18) - 1;
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   // result monitor: an item is taken at the rising edge with valid and ready high
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_result('{day: rsp_if.day_out, month: rsp_if.month_out,
                                year: rsp_if.year_out, date_ok: rsp_if.date_valid,
                                year_wrap: rsp_if.year_overflow});
   end

   // watchdog: ends the run once nothing has moved on either channel for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
      end
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic date_request_type make_date(int day, int month, int year, int add_days);
      date_request_type req;
      req.day      = DAY_W'(day);
      req.month    = MONTH_W'(month);
      req.year     = YEAR_W'(year);
      req.add_days = ADD_IN_W'(add_days);
      return req;
   endfunction

   // mostly well-formed dates with random content, weighted to the awkward years,
   // month ends and long additions; the rest is noise and broken days, months or years
   function automatic date_request_type random_date();
      date_request_type req;
      int unsigned      year;
      int unsigned      month;
      int unsigned      len;
      int unsigned      day;
      int unsigned      add_days;
      case ($urandom_range(0, 7))
         0: year = 65535 - $urandom_range(0, 4);
         1: year = 100 * $urandom_range(1, 655);
         2: year = 4 * $urandom_range(1, 16383);
         3: year = $urandom_range(1, 3);
         default: year = $urandom_range(1, 65535);
      endcase
      month = $urandom_range(1, 12);
      len   = tracker.month_days(month, year);
      case ($urandom_range(0, 3))
         0: day = len;
         1: day = 1;
         default: day = $urandom_range(1, len);
      endcase
      case ($urandom_range(0, 5))
         0: add_days = 0;
         1: add_days = $urandom_range(1, 40);
         2: add_days = MAX_ADD_DAYS;
         default: add_days = $urandom_range(0, (1 << ADD_IN_W) - 1);
      endcase
      case ($urandom_range(0, 19))
         0, 1: begin
            // pure noise over the whole field ranges
            req.day      = DAY_W'($urandom);
            req.month    = MONTH_W'($urandom);
            req.year     = YEAR_W'($urandom);
            req.add_days = ADD_IN_W'($urandom);
         end
         2: begin
            // day just past the month end, or zero
            req = make_date(len < 31 && $urandom_range(0, 1) ? len + 1 : 0,
                            month, year, add_days);
         end
         3: begin
            // broken month or year zero
            if ($urandom_range(0, 1))
               req = make_date(day, $urandom_range(13, 15) * $urandom_range(0, 1),
                               year, add_days);
            else
               req = make_date(day, month, 0, add_days);
         end
         default: req = make_date(day, month, year, add_days);
      endcase
      return req;
   endfunction

   // drive one date at the falling edge, hold it until it is taken
   task automatic send_date(input date_request_type req);
      int gap;
      if (req_idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.day_in      = req.day;
      req_if.month_in    = req.month;
      req_if.year_in     = req.year;
      req_if.days_to_add = req.add_days;
      do
         @(posedge clock);
      while (!req_if.ready);
      tracker.note_request(req);
      @(negedge clock);
   endtask

   initial begin
      date_request_type corner_dates[$];
      req_if.valid       = 1'b0;
      req_if.day_in      = '0;
      req_if.month_in    = '0;
      req_if.year_in     = '0;
      req_if.days_to_add = '0;
      rsp_if.ready       = 1'b0;

      // synchronous reset, released on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners: field extremes, leap rules, month and year ends, bad dates
      corner_dates = '{
         make_date(1, 1, 1, 0),            // smallest valid date, nothing added
         make_date(31, 12, 65535, 1),      // last day of the last year rolls over
         make_date(1, 1, 65535, 1023),     // most days from the last year
         make_date(30, 12, 65535, 1),      // stops one day short of the wrap
         make_date(29, 2, 2000, 1),        // leap day in a leap century
         make_date(29, 2, 1900, 0),        // no leap day in a plain century
         make_date(29, 2, 2100, 3),
         make_date(29, 2, 2400, 1023),
         make_date(29, 2, 2024, 365),      // leap day to the next year
         make_date(28, 2, 2023, 1),        // common year february end
         make_date(31, 1, 2020, 29),       // lands on a leap day
         make_date(31, 1, 2021, 28),
         make_date(31, 12, 1999, 1023),
         make_date(31, 12, 4, 1023),       // tiny year, leap every four
         make_date(31, 4, 2021, 5),        // day past a thirty day month
         make_date(0, 5, 2021, 5),         // day zero
         make_date(15, 0, 2021, 5),        // month zero
         make_date(15, 13, 2021, 5),       // month just past december
         make_date(10, 6, 0, 5),           // year zero
         make_date(31, 15, 65535, 1023),   // every input bit high
         make_date(0, 0, 0, 0),            // every input bit low
         make_date(1, 3, 65532, 1023),
         make_date(20, 7, 2023, 1023)
      };
      foreach (corner_dates[i])
         send_date(corner_dates[i]);

      // random part in segments: idling on, idling off, then a quiet tail
      for (int i = 0; i < RANDOM_DATES; i++) begin
         req_idling = (i < RANDOM_DATES - QUIET_TAIL) && ((i / 150) % 3 != 2);
         rsp_idling = (i < RANDOM_DATES - QUIET_TAIL) && ((i / 110) % 3 != 1);
         send_date(random_date());
      end
      req_if.valid = 1'b0;

      // let the pipeline drain, then watch a little longer for stray results
      while (tracker.pending_sums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.pending_sums.size() != 0) begin
         $error("%0d expected results never arrived", tracker.pending_sums.size());
         tracker.mismatches++;
      end
      $display("dates sent %0d: %0d valid, %0d past year 65535, %0d invalid",
               tracker.dates_noted, tracker.valid_dates, tracker.wrapped_years,
               tracker.dates_noted - tracker.valid_dates);
      $display("results compared %0d, mismatching items %0d",
               tracker.sums_checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
